/* rtl/pes_pkg.sv */
package pes_pkg;

  // Shared divider widths
  localparam int NUM_W = 64;
  localparam int DEN_W = 48;

  // Input command codes (s_tuser)
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Result status codes (m_tuser)
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_DIMS = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DITHER_AMPLITUDE = 3'd0,
    REG_DITHER_FREQUENCY = 3'd1,
    REG_INTEGRATOR_GAIN  = 3'd2,
    REG_HIGHPASS_POLE    = 3'd3,
    REG_LOWPASS_POLE     = 3'd4,
    REG_COMPENSATOR_ZERO = 3'd5,
    REG_COMPENSATOR_POLE = 3'd6,
    REG_SAMPLE_PERIOD    = 3'd7
  } reg_idx_t;

  // Fixed-point constants
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] COEF_LIMIT = 64'd1073741824;

endpackage

/* rtl/pes_div.sv */
module pes_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pes_pkg::NUM_W-1:0]     num,
  input  logic [pes_pkg::DEN_W-1:0]     den,
  output logic                          busy,
  output logic [pes_pkg::NUM_W-1:0]     quo,
  output logic [pes_pkg::DEN_W-1:0]     rem
);

  localparam int CNT_W = $clog2(pes_pkg::NUM_W);

  logic [CNT_W-1:0]            cnt;
  logic [pes_pkg::NUM_W-1:0]   work;
  logic [pes_pkg::DEN_W-1:0]   remr;
  logic [pes_pkg::DEN_W-1:0]   den_r;
  logic [pes_pkg::DEN_W:0]     shifted;
  logic                        fits;

  // Restoring step: shift in next dividend bit, subtract when it fits
  assign shifted = {remr, work[pes_pkg::NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      work  <= num;
      remr  <= '0;
      den_r <= den;
    end else if (busy) begin
      remr <= fits ? pes_pkg::DEN_W'(shifted - {1'b0, den_r})
                   : shifted[pes_pkg::DEN_W-1:0];
      work <= {work[pes_pkg::NUM_W-2:0], fits};
      cnt  <= cnt + 1'b1;
      if (cnt == CNT_W'(pes_pkg::NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = work;
  assign rem = remr;

endmodule

/* rtl/perturbation_extremum_seeking.sv */
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      s_tdata: objective_value, dimension_count; s_tuser: cmd
// m_*      out  m_tvalid / m_tready      m_tdata: position_ref, correction, dim_index;
//                                        m_tlast: last; m_tuser: status
// cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each step sends seven coefficient divisions, one phase offset division per dimension
// and two for the phase advance through one radix-2 divider; all products share one
// registered 34x34 multiplier. A reset command is handled in the idle state; an
// empty-count error result waits in the error state until the output is free.
// Reset is synchronous; state, configuration and filter state clear at once, no clearing pass.
// A stalled result holds the sequencer before the next dimension; s_tready is low
// while a step is in progress. SINE_TABLE_DEPTH must be a power of two.
module perturbation_extremum_seeking #(
  parameter int MAX_DIMS         = 8,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] objective_value, [35:32] dimension_count, zero pad
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] position_ref, [63:32] correction, [66:64] dim_index
  output logic        m_tlast,
  output logic        m_tuser,   // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W = $clog2(MAX_DIMS + 1);
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  typedef logic signed [17:0] sine_arr_t [SINE_TABLE_DEPTH];

  // Quarter-wave Taylor series mirrored to one full turn
  function automatic sine_arr_t build_sine();
    sine_arr_t   tab;
    logic [63:0] f;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] num;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      f   = 64'(4 * k);
      q   = f / SINE_TABLE_DEPTH;
      r   = f % SINE_TABLE_DEPTH;
      num = q[0] ? (64'(SINE_TABLE_DEPTH) - r) : r;
      x   = num * pes_pkg::HALF_PI_Q30 / SINE_TABLE_DEPTH;
      x2  = (x * x) >> 30;
      t   = pes_pkg::ONE_Q30 - x2 / 72;
      t   = pes_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
      t   = pes_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
      t   = pes_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
      s   = (((x * t) >> 30) + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      tab[k] = q[1] ? -$signed(18'(s)) : $signed(18'(s));
    end
    return tab;
  endfunction

  localparam sine_arr_t SINE_TABLE = build_sine();

  // Divide by 2^16 truncating toward zero
  function automatic logic signed [67:0] trunc16(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v + (v[67] ? 68'sd65535 : 68'sd0);
    return t >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE, ST_ERR, ST_POLE, ST_POLE_D, ST_COEF, ST_COEF_D, ST_DIVW,
    ST_HP0, ST_HP1, ST_HP2, ST_HP3, ST_HP4, ST_HP5,
    ST_OFF, ST_ROM, ST_D0, ST_D1, ST_D2, ST_D3,
    ST_L0, ST_L1, ST_L2, ST_L3,
    ST_C0, ST_C1, ST_C2, ST_C3, ST_C4,
    ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_P1,
    ST_PH0, ST_PH1, ST_PH2, ST_PH3
  } state_t;

  typedef enum logic [1:0] {PL_H, PL_L, PL_Z, PL_P} pole_t;

  typedef enum logic [2:0] {
    CF_CH, CF_GH, CF_CL, CF_GL, CF_C0, CF_C1, CF_C2
  } coef_t;

  state_t state;
  state_t ret;
  pole_t  pk;
  coef_t  cj;

  // Configuration
  logic [30:0]        amp;
  logic [30:0]        freq;
  logic signed [31:0] gain;
  logic [30:0]        hpole;
  logic [30:0]        lpole;
  logic [30:0]        czero;
  logic [30:0]        cpole;
  logic [30:0]        period;

  // Controller state
  logic signed [31:0] hp_prev;
  logic signed [31:0] obj_prev;
  logic [31:0]        phase;
  logic [CNT_W-1:0]   active_dims;
  logic               dims_latched;
  logic               first_done;
  logic signed [31:0] lp_prev [MAX_DIMS];
  logic signed [31:0] dm_prev [MAX_DIMS];
  logic signed [31:0] cp_prev [MAX_DIMS];
  logic signed [31:0] corr    [MAX_DIMS];

  // Working registers
  logic signed [31:0] obj_in;
  logic [46:0]        pole_prod [4];
  logic signed [31:0] coef [7];
  logic               cneg;
  logic signed [47:0] hamp;
  logic [DIM_W-1:0]   i;
  logic signed [17:0] sine;
  logic signed [67:0] acc;
  logic signed [67:0] tq;
  logic signed [31:0] d_val;
  logic signed [31:0] lp_val;
  logic signed [31:0] cp_val;
  logic signed [31:0] kc_val;
  logic signed [31:0] corr_new;
  logic signed [31:0] dith;

  // Shared multiplier
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;

  // Shared divider
  logic                          div_start;
  logic [pes_pkg::NUM_W-1:0]     div_num;
  logic [pes_pkg::DEN_W-1:0]     div_den;
  logic                          div_busy;
  logic [pes_pkg::NUM_W-1:0]     div_quo;
  logic [pes_pkg::DEN_W-1:0]     div_rem;

  // Output register
  logic signed [31:0] out_pos;
  logic signed [31:0] out_corr;
  logic [2:0]         out_idx;

  logic               out_free;
  logic               accept;
  logic [3:0]         cnt_in;
  logic               last_dim;
  logic [30:0]        pole_val;
  logic signed [65:0] ah_s;
  logic signed [65:0] al_s;
  logic signed [65:0] az_s;
  logic signed [65:0] ap_s;
  logic signed [65:0] cnum;
  logic [47:0]        cden;
  logic [63:0]        cmag;
  logic [31:0]        qmag;
  logic [31:0]        ph_sum;
  logic [IDX_W-1:0]   rom_idx;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign cnt_in    = s_tdata[35:32];
  assign out_free  = !m_tvalid || m_tready;
  assign last_dim  = (CNT_W'(i) + CNT_W'(1)) == active_dims;
  assign m_tdata   = {5'b0, out_idx, out_corr, out_pos};

  // Pole selection for the pole-period products
  always_comb begin
    unique case (pk)
      PL_H: pole_val = hpole;
      PL_L: pole_val = lpole;
      PL_Z: pole_val = czero;
      PL_P: pole_val = cpole;
    endcase
  end

  // Coefficient numerator and denominator
  assign ah_s = $signed({19'b0, pole_prod[PL_H]});
  assign al_s = $signed({19'b0, pole_prod[PL_L]});
  assign az_s = $signed({19'b0, pole_prod[PL_Z]});
  assign ap_s = $signed({19'b0, pole_prod[PL_P]});

  always_comb begin
    unique case (cj)
      CF_CH: begin
        cnum = (66'sd131072 - ah_s) <<< 16;
        cden = 48'(pole_prod[PL_H]) + 48'd131072;
      end
      CF_GH: begin
        cnum = 66'sd8589934592;
        cden = 48'(pole_prod[PL_H]) + 48'd131072;
      end
      CF_CL: begin
        cnum = (66'sd131072 - al_s) <<< 16;
        cden = 48'(pole_prod[PL_L]) + 48'd131072;
      end
      CF_GL: begin
        cnum = al_s <<< 16;
        cden = 48'(pole_prod[PL_L]) + 48'd131072;
      end
      CF_C0: begin
        cnum = (66'sd131072 + az_s) <<< 16;
        cden = 48'(pole_prod[PL_P]) + 48'd131072;
      end
      CF_C1: begin
        cnum = (az_s - 66'sd131072) <<< 16;
        cden = 48'(pole_prod[PL_P]) + 48'd131072;
      end
      CF_C2: begin
        cnum = (66'sd131072 - ap_s) <<< 16;
        cden = 48'(pole_prod[PL_P]) + 48'd131072;
      end
      default: begin
        cnum = '0;
        cden = 48'd1;
      end
    endcase
  end

  assign cmag = cnum[65] ? 64'(-cnum) : cnum[63:0];
  assign qmag = (div_quo > pes_pkg::COEF_LIMIT) ? 32'(pes_pkg::COEF_LIMIT) : div_quo[31:0];

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 48'd1;
    unique case (state)
      ST_COEF: begin
        div_start = 1'b1;
        div_num   = cmag;
        div_den   = cden;
      end
      ST_OFF: begin
        div_start = 1'b1;
        div_num   = 64'(i) << 31;
        div_den   = 48'(active_dims);
      end
      ST_PH1: begin
        div_start = 1'b1;
        div_num   = prod[63:0];
        div_den   = 48'(pes_pkg::TWO_PI_Q32);
      end
      ST_PH2: begin
        div_start = 1'b1;
        div_num   = 64'({div_rem[34:0], 28'b0});
        div_den   = 48'(pes_pkg::TWO_PI_Q32);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_POLE: begin
        ma = {3'b0, pole_val};
        mb = {3'b0, period};
      end
      ST_HP0: begin
        ma = 34'(coef[CF_CH]);
        mb = 34'(hp_prev);
      end
      ST_HP1: begin
        ma = 34'(coef[CF_GH]);
        mb = 34'(obj_in) - 34'(obj_prev);
      end
      ST_HP4: begin
        ma = 34'(hp_prev);
        mb = {3'b0, amp};
      end
      ST_D0: begin
        ma = 34'($signed(hamp[47:24]));
        mb = 34'(sine);
      end
      ST_D1: begin
        ma = {10'b0, hamp[23:0]};
        mb = 34'(sine);
      end
      ST_L0: begin
        ma = 34'(coef[CF_CL]);
        mb = 34'(lp_prev[i]);
      end
      ST_L1: begin
        ma = 34'(coef[CF_GL]);
        mb = 34'(d_val) + 34'(dm_prev[i]);
      end
      ST_C0: begin
        ma = 34'(coef[CF_C0]);
        mb = 34'(lp_val);
      end
      ST_C1: begin
        ma = 34'(coef[CF_C1]);
        mb = 34'(lp_prev[i]);
      end
      ST_C2: begin
        ma = 34'(coef[CF_C2]);
        mb = 34'(cp_prev[i]);
      end
      ST_K0: begin
        ma = 34'(gain);
        mb = 34'(cp_val);
      end
      ST_K2: begin
        ma = 34'(kc_val);
        mb = {3'b0, period};
      end
      ST_K3: begin
        ma = {3'b0, amp};
        mb = 34'(sine);
      end
      ST_PH0: begin
        ma = {3'b0, period};
        mb = {3'b0, freq};
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  // Sine lookup address: dither phase plus dimension offset
  assign ph_sum  = phase + div_quo[31:0];
  assign rom_idx = ph_sum[31 -: IDX_W];

  always_ff @(posedge clk) begin
    if (state == ST_ROM) begin
      sine <= SINE_TABLE[rom_idx];
    end
  end

  pes_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state        <= ST_IDLE;
      ret          <= ST_IDLE;
      pk           <= PL_H;
      cj           <= CF_CH;
      i            <= '0;
      m_tvalid     <= 1'b0;
      amp          <= '0;
      freq         <= '0;
      gain         <= '0;
      hpole        <= '0;
      lpole        <= '0;
      czero        <= '0;
      cpole        <= '0;
      period       <= '0;
      hp_prev      <= '0;
      obj_prev     <= '0;
      phase        <= '0;
      active_dims  <= '0;
      dims_latched <= 1'b0;
      first_done   <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        lp_prev[k] <= '0;
        dm_prev[k] <= '0;
        cp_prev[k] <= '0;
        corr[k]    <= '0;
      end
    end else begin
      // Drop a taken beat
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (pes_pkg::reg_idx_t'(cfg_index))
          pes_pkg::REG_DITHER_AMPLITUDE: amp    <= cfg_data[30:0];
          pes_pkg::REG_DITHER_FREQUENCY: freq   <= cfg_data[30:0];
          pes_pkg::REG_INTEGRATOR_GAIN:  gain   <= cfg_data;
          pes_pkg::REG_HIGHPASS_POLE:    hpole  <= cfg_data[30:0];
          pes_pkg::REG_LOWPASS_POLE:     lpole  <= cfg_data[30:0];
          pes_pkg::REG_COMPENSATOR_ZERO: czero  <= cfg_data[30:0];
          pes_pkg::REG_COMPENSATOR_POLE: cpole  <= cfg_data[30:0];
          pes_pkg::REG_SAMPLE_PERIOD:    period <= cfg_data[30:0];
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == pes_pkg::CMD_RESET) begin
              hp_prev      <= '0;
              obj_prev     <= '0;
              phase        <= '0;
              active_dims  <= '0;
              dims_latched <= 1'b0;
              first_done   <= 1'b0;
              for (int k = 0; k < MAX_DIMS; k++) begin
                lp_prev[k] <= '0;
                dm_prev[k] <= '0;
                cp_prev[k] <= '0;
                corr[k]    <= '0;
              end
            end else if (!dims_latched && cnt_in == 4'd0) begin
              state <= ST_ERR;
            end else begin
              if (!dims_latched) begin
                active_dims  <= (32'(cnt_in) > 32'(MAX_DIMS)) ? CNT_W'(MAX_DIMS)
                                                               : CNT_W'(cnt_in);
                dims_latched <= 1'b1;
                for (int k = 0; k < MAX_DIMS; k++) begin
                  lp_prev[k] <= '0;
                  dm_prev[k] <= '0;
                  cp_prev[k] <= '0;
                  corr[k]    <= '0;
                end
              end
              obj_in <= s_tdata[31:0];
              pk     <= PL_H;
              state  <= ST_POLE;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_pos  <= '0;
            out_corr <= '0;
            out_idx  <= '0;
            m_tlast  <= 1'b1;
            m_tuser  <= pes_pkg::STATUS_NO_DIMS;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_POLE: begin
          state <= ST_POLE_D;
        end
        ST_POLE_D: begin
          pole_prod[pk] <= prod[62:16];
          if (pk == PL_P) begin
            cj    <= CF_CH;
            state <= ST_COEF;
          end else begin
            pk    <= pole_t'(pk + 1'b1);
            state <= ST_POLE;
          end
        end
        ST_COEF: begin
          cneg  <= cnum[65];
          ret   <= ST_COEF_D;
          state <= ST_DIVW;
        end
        ST_COEF_D: begin
          coef[cj] <= cneg ? -$signed(qmag) : $signed(qmag);
          if (cj == CF_C2) begin
            state <= ST_HP0;
          end else begin
            cj    <= coef_t'(cj + 1'b1);
            state <= ST_COEF;
          end
        end
        ST_DIVW: begin
          if (!div_busy) begin
            state <= ret;
          end
        end
        // High-pass filter and amplitude scaling
        ST_HP0: state <= ST_HP1;
        ST_HP1: begin
          acc   <= prod;
          state <= ST_HP2;
        end
        ST_HP2: begin
          acc   <= acc + prod;
          state <= ST_HP3;
        end
        ST_HP3: begin
          hp_prev  <= sat32(trunc16(acc));
          obj_prev <= obj_in;
          state    <= ST_HP4;
        end
        ST_HP4: state <= ST_HP5;
        ST_HP5: begin
          hamp  <= trunc16(prod)[47:0];
          i     <= '0;
          state <= ST_OFF;
        end
        // Per-dimension chain
        ST_OFF: begin
          ret   <= ST_ROM;
          state <= ST_DIVW;
        end
        ST_ROM: state <= ST_D0;
        ST_D0:  state <= ST_D1;
        ST_D1: begin
          acc   <= prod <<< 24;
          state <= ST_D2;
        end
        ST_D2: begin
          acc   <= acc + prod;
          state <= ST_D3;
        end
        ST_D3: begin
          d_val <= sat32(trunc16(acc));
          state <= ST_L0;
        end
        ST_L0: state <= ST_L1;
        ST_L1: begin
          acc   <= prod;
          state <= ST_L2;
        end
        ST_L2: begin
          acc   <= acc + prod;
          state <= ST_L3;
        end
        ST_L3: begin
          lp_val <= sat32(trunc16(acc));
          state  <= ST_C0;
        end
        ST_C0: state <= ST_C1;
        ST_C1: begin
          acc   <= prod;
          state <= ST_C2;
        end
        ST_C2: begin
          acc   <= acc + prod;
          state <= ST_C3;
        end
        ST_C3: begin
          acc   <= acc + prod;
          state <= ST_C4;
        end
        ST_C4: begin
          cp_val <= sat32(trunc16(acc));
          state  <= ST_K0;
        end
        ST_K0: state <= ST_K1;
        ST_K1: begin
          kc_val <= sat32(trunc16(prod));
          state  <= ST_K2;
        end
        ST_K2: state <= ST_K3;
        ST_K3: begin
          tq    <= trunc16(prod);
          state <= ST_K4;
        end
        ST_K4: begin
          dith     <= trunc16(prod)[31:0];
          corr_new <= sat32(68'(corr[i]) + tq);
          state    <= ST_P1;
        end
        ST_P1: begin
          if (out_free) begin
            out_pos    <= first_done ? sat32(68'(corr_new) + 68'(dith)) : dith;
            out_corr   <= corr_new;
            out_idx    <= 3'(i);
            m_tlast    <= last_dim;
            m_tuser    <= pes_pkg::STATUS_OK;
            m_tvalid   <= 1'b1;
            corr[i]    <= corr_new;
            dm_prev[i] <= d_val;
            lp_prev[i] <= lp_val;
            cp_prev[i] <= cp_val;
            if (last_dim) begin
              state <= ST_PH0;
            end else begin
              i     <= i + 1'b1;
              state <= ST_OFF;
            end
          end
        end
        // Dither phase advance
        ST_PH0: state <= ST_PH1;
        ST_PH1: begin
          ret   <= ST_PH2;
          state <= ST_DIVW;
        end
        ST_PH2: begin
          ret   <= ST_PH3;
          state <= ST_DIVW;
        end
        ST_PH3: begin
          phase      <= phase + {div_quo[27:0], 4'b0};
          first_done <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pes_pkg::STATUS_NO_DIMS) |-> m_tlast)
    else $error("error result without last");

  a_rst_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == pes_pkg::CMD_RESET) |=> s_tready)
    else $error("reset command left block busy");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy)
    else $error("divider did not start");
`endif

endmodule
